// ===== rtl/core/rgb_to_hsl_core_macros.svh =====
// ---------------------------------------------------------------------------
// rgb_to_hsl_core_macros.svh - assertion helpers
// Concurrent assertion wrappers used by the RGB to HSL core.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CORE_MACROS_SVH
`define RGB_TO_HSL_CORE_MACROS_SVH

// checked only outside reset
`define RTH_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define RTH_CHECK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rth_pkg.sv =====
// ---------------------------------------------------------------------------
// rth_pkg - RGB to HSL shared definitions
// Widths, constants and the per-cell divider state type.
// ---------------------------------------------------------------------------
`default_nettype none

package rth_pkg;

   localparam int CH_W     = 8;   // channel byte
   localparam int SUM_W    = 9;   // max + min
   localparam int DIVH_W   = 11;  // 6*d, up to 1530
   localparam int DIVS_W   = 8;   // saturation denominator, up to 255
   localparam int SAT_W    = 16;
   localparam int SAT_FRAC = 15;  // Q1.15

   localparam logic [SAT_W-1:0]  SAT_ONE    = 16'h8000;
   // grey pixel: divisors forced to all ones with zero remainders -> zero quotients
   localparam logic [DIVH_W-1:0] GREY_DIV_H = 11'h7FF;
   localparam logic [DIVS_W-1:0] GREY_DIV_S = 8'hFF;

   typedef struct packed {
      logic [DIVH_W-1:0] rem_h;
      logic [DIVH_W-1:0] div_h;
      logic [DIVS_W-1:0] rem_s;
      logic [DIVS_W-1:0] div_s;
      logic              sat_full;   // d equals denominator, saturation is one
      logic [SUM_W-1:0]  light_sum;
   } div_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/rth_if.sv =====
// ---------------------------------------------------------------------------
// rth_if - pixel channels
// Valid/ready channels for RGB pixels in and HSL results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface rth_rgb_if;
   logic                      valid;
   logic                      ready;
   logic [rth_pkg::CH_W-1:0]  red;
   logic [rth_pkg::CH_W-1:0]  green;
   logic [rth_pkg::CH_W-1:0]  blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsl_if #(parameter int HUE_W = 16);
   logic                       valid;
   logic                       ready;
   logic [HUE_W-1:0]           hue;
   logic [rth_pkg::SAT_W-1:0]  saturation;
   logic [rth_pkg::SUM_W-1:0]  light_sum;

   modport source (output valid, output hue, output saturation, output light_sum,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input light_sum,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rth_prep.sv =====
// ---------------------------------------------------------------------------
// rth_prep - front cell
// Finds max/min, sector numerator and divisors; seeds the divider chain.
// ---------------------------------------------------------------------------
`default_nettype none

module rth_prep (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  wire [rth_pkg::CH_W-1:0]     in_red,
   input  wire [rth_pkg::CH_W-1:0]     in_green,
   input  wire [rth_pkg::CH_W-1:0]     in_blue,
   output logic                        out_valid,
   input  wire                         out_ready,
   output rth_pkg::div_state_type      out_data
);

   logic                            valid_ff;
   rth_pkg::div_state_type          data_ff;
   rth_pkg::div_state_type          data_in;

   logic [rth_pkg::CH_W-1:0]        mx;
   logic [rth_pkg::CH_W-1:0]        mn;
   logic [rth_pkg::CH_W-1:0]        d;
   logic [rth_pkg::SUM_W-1:0]       sum;
   logic [rth_pkg::SUM_W-1:0]       sum_hi;
   logic [rth_pkg::DIVH_W-1:0]      d_w;
   logic [rth_pkg::DIVH_W-1:0]      d6;
   logic [rth_pkg::DIVH_W-1:0]      num;
   logic [rth_pkg::DIVS_W-1:0]      denom;

   always_comb begin
      mx = (in_red > in_green) ? in_red : in_green;
      mx = (mx > in_blue) ? mx : in_blue;
      mn = (in_red < in_green) ? in_red : in_green;
      mn = (mn < in_blue) ? mn : in_blue;
      d   = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
      d_w = {3'b000, d};
      d6  = (d_w << 2) + (d_w << 1);

      // numerator = h6 * d, always below 6d; red wins ties, then green
      if (in_red == mx) begin
         if (in_green >= in_blue) begin
            num = {3'b000, in_green} - {3'b000, in_blue};
         end else begin
            num = d6 - ({3'b000, in_blue} - {3'b000, in_green});
         end
      end else if (in_green == mx) begin
         num = (d_w << 1) + {3'b000, in_blue} - {3'b000, in_red};
      end else begin
         num = (d_w << 2) + {3'b000, in_red} - {3'b000, in_green};
      end

      sum_hi = 9'd510 - sum;
      denom  = (sum <= 9'd255) ? sum[rth_pkg::DIVS_W-1:0] : sum_hi[rth_pkg::DIVS_W-1:0];

      data_in.light_sum = sum;
      if (d == '0) begin
         data_in.rem_h    = '0;
         data_in.div_h    = rth_pkg::GREY_DIV_H;
         data_in.rem_s    = '0;
         data_in.div_s    = rth_pkg::GREY_DIV_S;
         data_in.sat_full = 1'b0;
      end else begin
         data_in.rem_h    = num;
         data_in.div_h    = d6;
         data_in.div_s    = denom;
         data_in.sat_full = (d == denom);
         data_in.rem_s    = (d == denom) ? '0 : d;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rth_cell.sv =====
// ---------------------------------------------------------------------------
// rth_cell - divider cell
// One restoring division step for hue and for saturation, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module rth_cell #(
   parameter int QW = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  wire rth_pkg::div_state_type in_data,
   input  wire [QW-1:0]                in_qh,
   input  wire [QW-1:0]                in_qs,
   output logic                        out_valid,
   input  wire                         out_ready,
   output rth_pkg::div_state_type      out_data,
   output logic [QW-1:0]               out_qh,
   output logic [QW-1:0]               out_qs
);

   logic                            valid_ff;
   rth_pkg::div_state_type          data_ff;
   rth_pkg::div_state_type          data_in;
   logic [QW-1:0]                   qh_ff;
   logic [QW-1:0]                   qs_ff;
   logic [rth_pkg::DIVH_W:0]        tw_h;
   logic [rth_pkg::DIVH_W:0]        dif_h;
   logic [rth_pkg::DIVS_W:0]        tw_s;
   logic [rth_pkg::DIVS_W:0]        dif_s;
   logic                            ge_h;
   logic                            ge_s;

   always_comb begin
      tw_h  = {in_data.rem_h, 1'b0};
      ge_h  = tw_h >= {1'b0, in_data.div_h};
      dif_h = tw_h - {1'b0, in_data.div_h};
      tw_s  = {in_data.rem_s, 1'b0};
      ge_s  = tw_s >= {1'b0, in_data.div_s};
      dif_s = tw_s - {1'b0, in_data.div_s};

      data_in       = in_data;
      data_in.rem_h = ge_h ? dif_h[rth_pkg::DIVH_W-1:0] : tw_h[rth_pkg::DIVH_W-1:0];
      data_in.rem_s = ge_s ? dif_s[rth_pkg::DIVS_W-1:0] : tw_s[rth_pkg::DIVS_W-1:0];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_qh    = qh_ff;
   assign out_qs    = qs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
         qh_ff   <= {in_qh[QW-2:0], ge_h};
         qs_ff   <= {in_qs[QW-2:0], ge_s};
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rgb_to_hsl_core.sv =====
// ---------------------------------------------------------------------------
// rgb_to_hsl_core - RGB to HSL pixel converter
// Pipelined chain of restoring divider cells, one pixel per clock unless the output stalls.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  req_pix  | in  | valid/ready        | red, green, blue (8b each)
//  rsp_pix  | out | valid/ready        | hue (HUE_FRAC_BITS), saturation (Q1.15), light_sum (9b)
//
//  Throughput: one item per clock while rsp_pix is not stalled. Pipeline: the front cell, then
//  NCELL = max(HUE_FRAC_BITS, 15) divider cells, each producing one quotient bit.
//  Reset: synchronous, clears only the valid bit of each cell, with no clearing pass.
//  Stalls: each cell holds its item while the next one is full and stalled; empty slots
//  collapse, so input is taken while a finished result waits at the output.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rgb_to_hsl_core_macros.svh"

module rgb_to_hsl_core #(
   parameter int HUE_FRAC_BITS = 16
) (
   input  wire              clock,
   input  wire              reset,
   rth_rgb_if.sink          req_pix,
   rth_hsl_if.source        rsp_pix
);

   // enough steps for both quotients; extra steps only add low bits that are dropped
   localparam int NCELL = (HUE_FRAC_BITS > rth_pkg::SAT_FRAC) ? HUE_FRAC_BITS
                                                              : rth_pkg::SAT_FRAC;

   // chain taps: index 0 is the front cell output, index k the output of divider cell k-1
   logic                            chain_valid [NCELL+1];
   logic                            chain_ready [NCELL+1];
   rth_pkg::div_state_type          chain_data  [NCELL+1];
   logic [NCELL-1:0]                chain_qh    [NCELL+1];
   logic [NCELL-1:0]                chain_qs    [NCELL+1];

   logic                            last_valid;
   rth_pkg::div_state_type          last_data;
   logic [NCELL-1:0]                last_qh;
   logic [NCELL-1:0]                last_qs;

   // front cell: max/min, sector numerator, divisors
   rth_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_pix.valid),
      .in_ready  (req_pix.ready),
      .in_red    (req_pix.red),
      .in_green  (req_pix.green),
      .in_blue   (req_pix.blue),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // quotient registers start empty; NCELL shifts replace every bit
   assign chain_qh[0] = '0;
   assign chain_qs[0] = '0;

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      rth_cell #(
         .QW (NCELL)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .in_qh     (chain_qh[k]),
         .in_qs     (chain_qs[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1]),
         .out_qh    (chain_qh[k+1]),
         .out_qs    (chain_qs[k+1])
      );
   end

   assign last_valid         = chain_valid[NCELL];
   assign last_data          = chain_data[NCELL];
   assign last_qh            = chain_qh[NCELL];
   assign last_qs            = chain_qs[NCELL];
   assign chain_ready[NCELL] = rsp_pix.ready;

   // keep the top bits: floor of the longer quotient shifted right is the exact floor
   assign rsp_pix.valid      = last_valid;
   assign rsp_pix.hue        = last_qh[NCELL-1 -: HUE_FRAC_BITS];
   assign rsp_pix.saturation = {last_data.sat_full, last_qs[NCELL-1 -: rth_pkg::SAT_FRAC]};
   assign rsp_pix.light_sum  = last_data.light_sum;

   `RTH_CHECK(a_rem_bound, clock, reset, last_valid |-> ((last_data.rem_h < last_data.div_h) && (last_data.rem_s < last_data.div_s)), "divider remainder out of range")
   `RTH_CHECK(a_sat_one, clock, reset, (rsp_pix.valid && last_data.sat_full) |-> (rsp_pix.saturation == rth_pkg::SAT_ONE), "full saturation not exactly one")
   `RTH_CHECK(a_grey_zero, clock, reset, (rsp_pix.valid && (last_data.div_h == rth_pkg::GREY_DIV_H)) |-> ((rsp_pix.hue == '0) && (rsp_pix.saturation == '0)), "grey pixel with nonzero hue or saturation")
   `RTH_CHECK_ALWAYS(a_drain_ready, clock, (!reset && !last_valid) |-> req_pix.ready, "input stalled with empty output cell")

endmodule

`default_nettype wire
